### rtl/wsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types, constants and tables for the weather safety check.
// ----------------------------------------------------------------------------
package wsc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam int PW           = 2 * CW;
    localparam int SQ_STEPS     = 31;

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] SQ_LAST     = 5'(SQ_STEPS - 1);

    localparam logic signed [CW-1:0] ANG_HALF_PI = CW'(421657428);
    localparam logic signed [CW-1:0] ANG_PI      = CW'(843314857);
    localparam logic signed [CW-1:0] ANG_TWO_PI  = CW'(1686629713);
    localparam logic signed [CW-1:0] CORDIC_K    = CW'(652032874);
    localparam logic signed [CW-1:0] EARTH_R     = CW'(225699331);
    localparam logic [30:0]          ONE_Q30     = 31'(1073741824);
    localparam logic [16:0]          PROB_ONE    = 17'(65536);

    localparam logic [2:0] REG_CENTER_LAT = 3'd0;
    localparam logic [2:0] REG_CENTER_LON = 3'd1;
    localparam logic [2:0] REG_LAT_STEP   = 3'd2;
    localparam logic [2:0] REG_LON_STEP   = 3'd3;
    localparam logic [2:0] REG_DANGER_THR = 3'd4;
    localparam logic [2:0] REG_SAFETY_THR = 3'd5;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_ANG_MUL, OP_ANG_WR, OP_ROT_INIT, OP_ROT_STEP,
        OP_MUL_SS, OP_WR_HLAT, OP_WR_HLON, OP_WR_C1, OP_MUL_CC, OP_WR_CC,
        OP_MUL_CH, OP_WR_A, OP_SQ_INIT, OP_SQ_STEP, OP_SQ_DONE, OP_VEC_STEP,
        OP_DIST_MUL, OP_DIST_CMP, OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic need_test;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic signed [31:0] center_lat;
        logic signed [31:0] center_lon;
        logic signed [31:0] lat_step;
        logic signed [31:0] lon_step;
        logic [16:0]        danger_thr;
        logic [16:0]        safety_thr;
    } cfg_t;

    function automatic logic signed [CW-1:0] atan_q28(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:    r = CW'(210828714);
            5'd1:    r = CW'(124459457);
            5'd2:    r = CW'(65760959);
            5'd3:    r = CW'(33381290);
            5'd4:    r = CW'(16755422);
            5'd5:    r = CW'(8385879);
            5'd6:    r = CW'(4193963);
            5'd7:    r = CW'(2097109);
            5'd8:    r = CW'(1048571);
            5'd9:    r = CW'(524287);
            5'd10:   r = CW'(262144);
            5'd11:   r = CW'(131072);
            5'd12:   r = CW'(65536);
            5'd13:   r = CW'(32768);
            5'd14:   r = CW'(16384);
            5'd15:   r = CW'(8192);
            5'd16:   r = CW'(4096);
            5'd17:   r = CW'(2048);
            5'd18:   r = CW'(1024);
            5'd19:   r = CW'(512);
            5'd20:   r = CW'(256);
            5'd21:   r = CW'(128);
            5'd22:   r = CW'(64);
            5'd23:   r = CW'(32);
            5'd24:   r = CW'(16);
            5'd25:   r = CW'(8);
            5'd26:   r = CW'(4);
            5'd27:   r = CW'(2);
            5'd28:   r = CW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/wsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_ctrl
// Sequencer: steps the datapath through angle mapping, CORDIC, square root
// and the distance compare for one item.
// ----------------------------------------------------------------------------
module wsc_ctrl
    import wsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ANG_MUL, S_ANG_WR, S_ROT_INIT, S_ROT_STEP, S_POST,
        S_SQ_INIT, S_SQ_STEP, S_SQ_DONE, S_VEC_STEP, S_DIST_MUL, S_DIST_CMP,
        S_CLOSE
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic [1:0] post_reg;
    logic [4:0] cnt_reg;
    logic       post_last;

    always_comb
    begin
        case (idx_reg)
            2'd2:    post_last = (post_reg == 2'd0);
            2'd3:    post_last = (post_reg == 2'd3);
            default: post_last = (post_reg == 2'd1);
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.sel  = idx_reg;
        cmd.step = cnt_reg;
        case (state_reg)
            S_IDLE:     cmd.op = in_valid ? OP_LATCH : OP_NONE;
            S_ANG_MUL:  cmd.op = OP_ANG_MUL;
            S_ANG_WR:   cmd.op = OP_ANG_WR;
            S_ROT_INIT: cmd.op = OP_ROT_INIT;
            S_ROT_STEP: cmd.op = OP_ROT_STEP;
            S_POST:
            begin
                case (idx_reg)
                    2'd0:    cmd.op = (post_reg == 2'd0) ? OP_MUL_SS : OP_WR_HLAT;
                    2'd1:    cmd.op = (post_reg == 2'd0) ? OP_MUL_SS : OP_WR_HLON;
                    2'd2:    cmd.op = OP_WR_C1;
                    default:
                    begin
                        case (post_reg)
                            2'd0:    cmd.op = OP_MUL_CC;
                            2'd1:    cmd.op = OP_WR_CC;
                            2'd2:    cmd.op = OP_MUL_CH;
                            default: cmd.op = OP_WR_A;
                        endcase
                    end
                endcase
            end
            S_SQ_INIT:  cmd.op = OP_SQ_INIT;
            S_SQ_STEP:  cmd.op = OP_SQ_STEP;
            S_SQ_DONE:  cmd.op = OP_SQ_DONE;
            S_VEC_STEP: cmd.op = OP_VEC_STEP;
            S_DIST_MUL: cmd.op = OP_DIST_MUL;
            S_DIST_CMP: cmd.op = OP_DIST_CMP;
            S_CLOSE:    cmd.op = sts.out_free ? OP_CLOSE : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            post_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    idx_reg   <= '0;
                    state_reg <= sts.need_test ? S_ANG_MUL : S_CLOSE;
                end
                S_ANG_MUL:  state_reg <= S_ANG_WR;
                S_ANG_WR:
                begin
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= (idx_reg == 2'd3) ? S_ROT_INIT : S_ANG_MUL;
                end
                S_ROT_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROT_STEP;
                end
                S_ROT_STEP:
                begin
                    cnt_reg  <= cnt_reg + 5'd1;
                    post_reg <= '0;
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    post_reg <= post_reg + 2'd1;
                    if (post_last)
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= (idx_reg == 2'd3) ? S_SQ_INIT : S_ROT_INIT;
                    end
                end
                S_SQ_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQ_STEP;
                end
                S_SQ_STEP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == SQ_LAST)
                        state_reg <= S_SQ_DONE;
                end
                S_SQ_DONE:
                begin
                    cnt_reg <= '0;
                    if (idx_reg == 2'd0)
                    begin
                        idx_reg   <= 2'd1;
                        state_reg <= S_SQ_INIT;
                    end
                    else
                        state_reg <= S_VEC_STEP;
                end
                S_VEC_STEP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= S_DIST_MUL;
                end
                S_DIST_MUL: state_reg <= S_DIST_CMP;
                S_DIST_CMP: state_reg <= S_CLOSE;
                S_CLOSE:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/wsc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_datapath
// Item registers, shared multiplier, CORDIC unit, square root unit, node
// accumulators and the result register.
// ----------------------------------------------------------------------------
module wsc_datapath
    import wsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  cfg_t               cfg,
    input  logic signed [15:0] node_px,
    input  logic signed [15:0] node_py,
    input  logic [31:0]        node_margin,
    input  logic signed [15:0] cell_px,
    input  logic signed [15:0] cell_py,
    input  logic [16:0]        cell_danger,
    input  logic [31:0]        cell_size,
    input  logic [16:0]        ensemble_weight,
    input  logic               cell_present,
    input  logic               ensemble_end,
    input  logic               node_end,
    input  logic               in_tree,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [16:0]        safe_probability,
    output logic               node_invalid,
    output logic [31:0]        invalid_total
);

    logic signed [15:0] npx_reg, npy_reg, cpx_reg, cpy_reg;
    logic [31:0]        margin_reg, size_reg;
    logic [16:0]        danger_reg, weight_reg;
    logic               present_reg, e_end_reg, n_end_reg, tree_reg;

    logic signed [31:0] nlat_reg, nlon_reg, wlat_reg, wlon_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;
    logic signed [CW-1:0] hlat_reg, hlon_reg, c1_reg, cc_reg;
    logic [30:0]          a_reg, sy_reg;
    logic [61:0]          rem_reg, root_reg;
    logic [60:0]          bit_reg;
    logic signed [PW-1:0] prod_reg;

    logic        hit_reg;
    logic [16:0] sum_reg;
    logic [31:0] tally_reg;
    logic        out_valid_reg;
    logic [16:0] out_sum_reg;
    logic        out_bad_reg;

    logic signed [CW-1:0] ma, mb, sn, cs, rot_src, rz0, rz1;
    logic signed [32:0]   ang_diff;
    logic signed [31:0]   ang_origin;
    logic signed [49:0]   ang_sum;
    logic signed [31:0]   ang_sat;
    logic signed [CW:0]   a_sum;
    logic [60:0]          sq_in;
    logic [61:0]          sq_trial;
    logic signed [CW-1:0] cx_sh, cy_sh, atan_v;
    logic [31:0]          range_q16;
    logic [32:0]          limit;
    logic [17:0]          sum_add;
    logic [16:0]          sum_close;
    logic                 bad;

    assign sn = flip_reg ? -cy_reg : cy_reg;
    assign cs = flip_reg ? -cx_reg : cx_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_ANG_MUL:
            begin
                case (cmd.sel)
                    2'd0:    ma = CW'(npx_reg);
                    2'd1:    ma = CW'(npy_reg);
                    2'd2:    ma = CW'(cpx_reg);
                    default: ma = CW'(cpy_reg);
                endcase
                mb = cmd.sel[0] ? CW'(cfg.lon_step) : CW'(cfg.lat_step);
            end
            OP_MUL_SS:
            begin
                ma = sn;
                mb = sn;
            end
            OP_MUL_CC:
            begin
                ma = c1_reg;
                mb = cs;
            end
            OP_MUL_CH:
            begin
                ma = cc_reg;
                mb = hlon_reg;
            end
            OP_DIST_MUL:
            begin
                ma = cz_reg[CW-1] ? '0 : cz_reg;
                mb = EARTH_R;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        ang_origin = cmd.sel[0] ? cfg.center_lon : cfg.center_lat;
        ang_sum    = 50'(ang_origin) + prod_reg[49:0];
        if (ang_sum > 50'sd2147483647)
            ang_sat = 32'sh7FFFFFFF;
        else if (ang_sum < -50'sd2147483648)
            ang_sat = 32'sh80000000;
        else
            ang_sat = ang_sum[31:0];
    end

    always_comb
    begin
        ang_diff = '0;
        case (cmd.sel)
            2'd0:
            begin
                ang_diff = 33'(wlat_reg) - 33'(nlat_reg);
                rot_src  = CW'(ang_diff >>> 1);
            end
            2'd1:
            begin
                ang_diff = 33'(wlon_reg) - 33'(nlon_reg);
                rot_src  = CW'(ang_diff >>> 1);
            end
            2'd2:    rot_src = CW'(nlat_reg);
            default: rot_src = CW'(wlat_reg);
        endcase
        if (rot_src > ANG_PI)
            rz0 = rot_src - ANG_TWO_PI;
        else if (rot_src < -ANG_PI)
            rz0 = rot_src + ANG_TWO_PI;
        else
            rz0 = rot_src;
        if (rz0 > ANG_HALF_PI)
            rz1 = rz0 - ANG_PI;
        else if (rz0 < -ANG_HALF_PI)
            rz1 = rz0 + ANG_PI;
        else
            rz1 = rz0;
    end

    assign cx_sh  = cx_reg >>> cmd.step;
    assign cy_sh  = cy_reg >>> cmd.step;
    assign atan_v = atan_q28(cmd.step);

    assign a_sum    = (CW + 1)'(hlat_reg) + (CW + 1)'($signed(prod_reg[63:30]));
    assign sq_in    = (cmd.sel == 2'd0) ? {a_reg[30:0], 30'd0}
                                        : {ONE_Q30 - a_reg, 30'd0};
    assign sq_trial = root_reg + 62'(bit_reg);

    assign range_q16 = prod_reg[58:27];
    assign limit     = 33'(margin_reg) + 33'(size_reg);

    assign sum_add   = 18'(sum_reg) + 18'(weight_reg);
    assign sum_close = (!(e_end_reg || n_end_reg) || hit_reg) ? sum_reg
                     : ((sum_add > 18'(PROB_ONE)) ? PROB_ONE : sum_add[16:0]);
    assign bad       = tree_reg && (sum_close < cfg.safety_thr);

    assign sts.need_test = present_reg && !hit_reg && (danger_reg >= cfg.danger_thr);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (cmd.op)
            OP_LATCH:
            begin
                npx_reg     <= node_px;
                npy_reg     <= node_py;
                margin_reg  <= node_margin;
                cpx_reg     <= cell_px;
                cpy_reg     <= cell_py;
                danger_reg  <= cell_danger;
                size_reg    <= cell_size;
                weight_reg  <= ensemble_weight;
                present_reg <= cell_present;
                e_end_reg   <= ensemble_end;
                n_end_reg   <= node_end;
                tree_reg    <= in_tree;
            end
            OP_ANG_WR:
            begin
                case (cmd.sel)
                    2'd0:    nlat_reg <= ang_sat;
                    2'd1:    nlon_reg <= ang_sat;
                    2'd2:    wlat_reg <= ang_sat;
                    default: wlon_reg <= ang_sat;
                endcase
            end
            OP_ROT_INIT:
            begin
                cx_reg   <= CORDIC_K;
                cy_reg   <= '0;
                cz_reg   <= rz1;
                flip_reg <= (rz1 != rz0);
            end
            OP_ROT_STEP:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            OP_WR_HLAT: hlat_reg <= prod_reg[63:30];
            OP_WR_HLON: hlon_reg <= prod_reg[63:30];
            OP_WR_C1:   c1_reg   <= cs;
            OP_WR_CC:   cc_reg   <= prod_reg[63:30];
            OP_WR_A:
            begin
                if (a_sum[CW])
                    a_reg <= '0;
                else if (a_sum > (CW + 1)'(ONE_Q30))
                    a_reg <= ONE_Q30;
                else
                    a_reg <= a_sum[30:0];
            end
            OP_SQ_INIT:
            begin
                rem_reg  <= 62'(sq_in);
                root_reg <= '0;
                bit_reg  <= 61'd1 << 60;
            end
            OP_SQ_STEP:
            begin
                if (rem_reg >= sq_trial)
                begin
                    rem_reg  <= rem_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + 62'(bit_reg);
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            OP_SQ_DONE:
            begin
                if (cmd.sel == 2'd0)
                    sy_reg <= root_reg[30:0];
                else
                begin
                    cx_reg <= CW'(root_reg[30:0]);
                    cy_reg <= CW'(sy_reg);
                    cz_reg <= '0;
                end
            end
            OP_VEC_STEP:
            begin
                if (!cy_reg[CW-1])
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            OP_CLOSE:
            begin
                out_sum_reg <= sum_close;
                out_bad_reg <= bad;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            sum_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_DIST_CMP && {1'b0, range_q16} < limit)
                hit_reg <= 1'b1;
            if (cmd.op == OP_CLOSE)
            begin
                if (e_end_reg || n_end_reg)
                    hit_reg <= 1'b0;
                sum_reg <= n_end_reg ? '0 : sum_close;
                if (n_end_reg && bad && tally_reg != 32'hFFFFFFFF)
                    tally_reg <= tally_reg + 32'd1;
            end
            if (cmd.op == OP_CLOSE && n_end_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign safe_probability = out_sum_reg;
    assign node_invalid     = out_bad_reg;
    assign invalid_total    = tally_reg;

endmodule

### rtl/node_weather_safety_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_weather_safety_check
// Great-circle weather safety check per routing node with APB registers.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata
//  input    | in_valid / in_ready  | node, cell and ensemble fields
//  output   | out_valid / out_ready| safe_probability, node_invalid, total
//
// An item that tests a cell runs four rotation passes and one vectoring pass
// of the shared CORDIC unit and two 31-step square roots, with the single
// multiplier, between one input transfer and the next. An item with no test
// goes straight from its check to its close.
// Reset clears the APB registers, the node sums and the invalid count.
// A result waiting in the output register holds every later item at its close.
// ----------------------------------------------------------------------------
module node_weather_safety_check
    import wsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] node_px,
    input  logic signed [15:0] node_py,
    input  logic [31:0]        node_margin,
    input  logic signed [15:0] cell_px,
    input  logic signed [15:0] cell_py,
    input  logic [16:0]        cell_danger,
    input  logic [31:0]        cell_size,
    input  logic [16:0]        ensemble_weight,
    input  logic               cell_present,
    input  logic               ensemble_end,
    input  logic               node_end,
    input  logic               in_tree,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [16:0]        safe_probability,
    output logic               node_invalid,
    output logic [31:0]        invalid_total
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_CENTER_LAT: cfg_reg.center_lat <= pwdata;
                REG_CENTER_LON: cfg_reg.center_lon <= pwdata;
                REG_LAT_STEP:   cfg_reg.lat_step   <= pwdata;
                REG_LON_STEP:   cfg_reg.lon_step   <= pwdata;
                REG_DANGER_THR: cfg_reg.danger_thr <= pwdata[16:0];
                REG_SAFETY_THR: cfg_reg.safety_thr <= pwdata[16:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_CENTER_LAT: prdata = cfg_reg.center_lat;
            REG_CENTER_LON: prdata = cfg_reg.center_lon;
            REG_LAT_STEP:   prdata = cfg_reg.lat_step;
            REG_LON_STEP:   prdata = cfg_reg.lon_step;
            REG_DANGER_THR: prdata = 32'(cfg_reg.danger_thr);
            REG_SAFETY_THR: prdata = 32'(cfg_reg.safety_thr);
            default:        prdata = '0;
        endcase
    end

    wsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg              (cfg_reg),
        .node_px          (node_px),
        .node_py          (node_py),
        .node_margin      (node_margin),
        .cell_px          (cell_px),
        .cell_py          (cell_py),
        .cell_danger      (cell_danger),
        .cell_size        (cell_size),
        .ensemble_weight  (ensemble_weight),
        .cell_present     (cell_present),
        .ensemble_end     (ensemble_end),
        .node_end         (node_end),
        .in_tree          (in_tree),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .safe_probability (safe_probability),
        .node_invalid     (node_invalid),
        .invalid_total    (invalid_total)
    );

endmodule
